>>> design/atd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atd_pkg
// Types, constants and arithmetic step functions shared by the affine
// transform decompose pipeline and its checker.
// ----------------------------------------------------------------------------
package atd_pkg;

   localparam int DATA_WIDTH = 32;              // Q16.16 fields
   localparam int QUAT_WIDTH = 32;              // Q2.30 fields
   localparam int WIDE_WIDTH = 34;              // trace, root argument, numerators
   localparam int REM_WIDTH  = 66;              // divider remainder
   localparam int SQ_WIDTH   = 64;              // square root radicand
   localparam int SQ_STEPS   = 32;              // one result bit per stage
   localparam int DIV_STEPS  = 32;              // one quotient bit per stage
   localparam int QSHIFT     = 30;
   // input, square, sum, normalize, trace, branch and output stages
   localparam int LATENCY    = 7 + 2 * SQ_STEPS + 2 * DIV_STEPS;

   localparam logic [QUAT_WIDTH-1:0] QONE = 32'h4000_0000;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [WIDE_WIDTH-1:0] wide_type;

   typedef struct packed {
      data_type c0x;
      data_type c0y;
      data_type c0z;
      data_type c1x;
      data_type c1y;
      data_type c1z;
      data_type c2x;
      data_type c2y;
      data_type c2z;
      data_type tx;
      data_type ty;
      data_type tz;
   } req_type;

   typedef struct packed {
      data_type                pos_x;
      data_type                pos_y;
      data_type                pos_z;
      logic [DATA_WIDTH-1:0]   scale_x;
      logic [DATA_WIDTH-1:0]   scale_y;
      logic [DATA_WIDTH-1:0]   scale_z;
      logic signed [QUAT_WIDTH-1:0] quat_w;
      logic signed [QUAT_WIDTH-1:0] quat_x;
      logic signed [QUAT_WIDTH-1:0] quat_y;
      logic signed [QUAT_WIDTH-1:0] quat_z;
      logic                    degenerate;
   } rsp_type;

   typedef struct packed {
      logic [SQ_WIDTH-1:0] n;
      logic [SQ_WIDTH-1:0] res;
   } sqrt_type;

   typedef struct packed {
      logic [REM_WIDTH-1:0]  rem;
      logic [WIDE_WIDTH-1:0] den;
      logic [QUAT_WIDTH-1:0] q;
      logic                  neg;
      logic                  ovf;
   } div_type;

   // per-item data that rides along after the column lengths are known
   typedef struct packed {
      logic [2:0][DATA_WIDTH-1:0] pos;
      logic [2:0][DATA_WIDTH-1:0] scale;
      logic                       degen;
   } side_b_type;

   // slot 0 is w, slots 1..3 are x, y, z
   typedef struct packed {
      side_b_type                 b;
      logic [3:0][WIDE_WIDTH-1:0] num;
      logic [3:0]                 slot;
   } side_c_type;

   typedef struct packed {
      side_b_type            b;
      logic [3:0]            slot;
      logic [DATA_WIDTH-1:0] root;
   } side_d_type;

   // one digit of the bit-pair integer square root
   function automatic sqrt_type sqrt_step(sqrt_type cur, int step);
      logic [SQ_WIDTH-1:0] bitv;
      logic [SQ_WIDTH-1:0] trial;
      sqrt_type            nxt;
      bitv  = SQ_WIDTH'(1) << (SQ_WIDTH - 2 - 2 * step);
      trial = cur.res + bitv;
      nxt   = cur;
      if (cur.n >= trial) begin
         nxt.n   = cur.n - trial;
         nxt.res = (cur.res >> 1) + bitv;
      end else begin
         nxt.res = cur.res >> 1;
      end
      return nxt;
   endfunction

   function automatic div_type div_init(wide_type num, logic [WIDE_WIDTH-1:0] den);
      logic [WIDE_WIDTH-1:0] mag;
      div_type               d;
      mag   = num[WIDE_WIDTH-1] ? WIDE_WIDTH'(-num) : WIDE_WIDTH'(num);
      d.rem = REM_WIDTH'(mag) << QSHIFT;
      d.den = den;
      d.q   = '0;
      d.neg = num[WIDE_WIDTH-1];
      // quotient of 2^31 or more: saturate, the long division result is ignored
      d.ovf = {1'b0, mag} >= {den, 1'b0};
      return d;
   endfunction

   function automatic div_type div_step(div_type cur, int step);
      logic [REM_WIDTH-1:0] sub;
      div_type              nxt;
      nxt = cur;
      sub = REM_WIDTH'(cur.den) << (DIV_STEPS - 1 - step);
      if (cur.rem >= sub) begin
         nxt.rem = cur.rem - sub;
         nxt.q[DIV_STEPS - 1 - step] = 1'b1;
      end
      return nxt;
   endfunction

   function automatic logic [QUAT_WIDTH-1:0] div_final(div_type d);
      logic [QUAT_WIDTH-1:0] qv;
      qv = (d.ovf || (d.q > QONE)) ? QONE : d.q;
      return d.neg ? QUAT_WIDTH'(-qv) : qv;
   endfunction

endpackage
`default_nettype wire

>>> design/affine_transform_decompose.sv
`default_nettype none
// ----------------------------------------------------------------------------
// affine_transform_decompose
// Splits an affine transform into translation, per-axis scale and a unit
// rotation quaternion (trace or largest-diagonal extraction).
// ----------------------------------------------------------------------------
//  channel  ports                      handshake
//  request  req_data (req_type)        start, busy
//  result   rsp_data (rsp_type)        rsp_valid strobe, one cycle
//
//  The result strobe follows the accepting edge through every pipeline stage:
//  two 32-stage square roots and two 32-stage dividers, one bit per stage,
//  plus seven stages for the rest. A new transform is taken every cycle while
//  busy is low.
//  busy is high only during reset; reset clears the valid line, so no
//  result comes out for items in flight. Results are never held back.
// ----------------------------------------------------------------------------
module affine_transform_decompose (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  atd_pkg::req_type    req_data,
   output logic                rsp_valid,
   output atd_pkg::rsp_type    rsp_data
);

   localparam int SQ = atd_pkg::SQ_STEPS;
   localparam int DV = atd_pkg::DIV_STEPS;
   localparam int LT = atd_pkg::LATENCY;
   localparam int DW = atd_pkg::DATA_WIDTH;
   localparam int WW = atd_pkg::WIDE_WIDTH;

   // valid line
   logic [LT-1:0] vld_ff, vld_in;

   assign busy   = reset;
   assign vld_in = {vld_ff[LT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // input register
   atd_pkg::req_type in_ff;
   always_ff @(posedge clock) begin
      in_ff <= req_data;
   end

   // squares
   atd_pkg::data_type comp [9];
   logic [DW-1:0]     cmag [9];
   logic [63:0]       sq_in [9];
   logic [63:0]       sq_ff [9];
   atd_pkg::req_type  sq_req_ff;

   assign comp[0] = in_ff.c0x;
   assign comp[1] = in_ff.c0y;
   assign comp[2] = in_ff.c0z;
   assign comp[3] = in_ff.c1x;
   assign comp[4] = in_ff.c1y;
   assign comp[5] = in_ff.c1z;
   assign comp[6] = in_ff.c2x;
   assign comp[7] = in_ff.c2y;
   assign comp[8] = in_ff.c2z;

   always_comb begin
      for (int e = 0; e < 9; e++) begin
         cmag[e]  = comp[e][DW-1] ? DW'(-comp[e]) : DW'(comp[e]);
         sq_in[e] = 64'(cmag[e]) * 64'(cmag[e]);
      end
   end

   always_ff @(posedge clock) begin
      sq_ff     <= sq_in;
      sq_req_ff <= in_ff;
   end

   // sums of squares
   logic [63:0]      sum_ff [3];
   atd_pkg::req_type sum_req_ff;

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         sum_ff[c] <= sq_ff[3*c] + sq_ff[3*c+1] + sq_ff[3*c+2];
      end
      sum_req_ff <= sq_req_ff;
   end

   // column lengths
   atd_pkg::sqrt_type sqa_src [SQ][3];
   atd_pkg::sqrt_type sqa_in  [SQ][3];
   atd_pkg::sqrt_type sqa_ff  [SQ][3];
   atd_pkg::req_type  sa_src  [SQ];
   atd_pkg::req_type  sa_ff   [SQ];

   for (genvar gk = 0; gk < SQ; gk++) begin : g_sqa
      if (gk == 0) begin : g_src
         for (genvar gc = 0; gc < 3; gc++) begin : g_col
            assign sqa_src[gk][gc] = {sum_ff[gc], 64'd0};
         end
         assign sa_src[gk] = sum_req_ff;
      end else begin : g_src
         assign sqa_src[gk] = sqa_ff[gk-1];
         assign sa_src[gk]  = sa_ff[gk-1];
      end
      for (genvar gc = 0; gc < 3; gc++) begin : g_step
         assign sqa_in[gk][gc] = atd_pkg::sqrt_step(sqa_src[gk][gc], gk);
      end
      always_ff @(posedge clock) begin
         sqa_ff[gk] <= sqa_in[gk];
         sa_ff[gk]  <= sa_src[gk];
      end
   end

   // normalize each component by its column length
   atd_pkg::req_type   sa_last;
   atd_pkg::side_b_type b_start;
   atd_pkg::data_type  ncomp [9];

   assign sa_last = sa_ff[SQ-1];
   assign ncomp[0] = sa_last.c0x;
   assign ncomp[1] = sa_last.c0y;
   assign ncomp[2] = sa_last.c0z;
   assign ncomp[3] = sa_last.c1x;
   assign ncomp[4] = sa_last.c1y;
   assign ncomp[5] = sa_last.c1z;
   assign ncomp[6] = sa_last.c2x;
   assign ncomp[7] = sa_last.c2y;
   assign ncomp[8] = sa_last.c2z;

   always_comb begin
      b_start.pos[0] = sa_last.tx;
      b_start.pos[1] = sa_last.ty;
      b_start.pos[2] = sa_last.tz;
      for (int c = 0; c < 3; c++) begin
         b_start.scale[c] = sqa_ff[SQ-1][c].res[DW-1:0];
      end
      b_start.degen = (b_start.scale[0] == '0) || (b_start.scale[1] == '0) ||
                      (b_start.scale[2] == '0);
   end

   atd_pkg::div_type    dva_src [DV][9];
   atd_pkg::div_type    dva_in  [DV][9];
   atd_pkg::div_type    dva_ff  [DV][9];
   atd_pkg::side_b_type db_src  [DV];
   atd_pkg::side_b_type db_ff   [DV];

   for (genvar gk = 0; gk < DV; gk++) begin : g_dva
      if (gk == 0) begin : g_src
         for (genvar ge = 0; ge < 9; ge++) begin : g_el
            assign dva_src[gk][ge] = atd_pkg::div_init(WW'(ncomp[ge]),
                                        WW'(b_start.scale[ge/3]));
         end
         assign db_src[gk] = b_start;
      end else begin : g_src
         assign dva_src[gk] = dva_ff[gk-1];
         assign db_src[gk]  = db_ff[gk-1];
      end
      for (genvar ge = 0; ge < 9; ge++) begin : g_step
         assign dva_in[gk][ge] = atd_pkg::div_step(dva_src[gk][ge], gk);
      end
      always_ff @(posedge clock) begin
         dva_ff[gk] <= dva_in[gk];
         db_ff[gk]  <= db_src[gk];
      end
   end

   // rotation matrix elements, index column*3 + component
   atd_pkg::data_type   r_ff [9];
   atd_pkg::side_b_type rb_ff;

   always_ff @(posedge clock) begin
      for (int e = 0; e < 9; e++) begin
         r_ff[e] <= atd_pkg::div_final(dva_ff[DV-1][e]);
      end
      rb_ff <= db_ff[DV-1];
   end

   // trace and largest diagonal
   atd_pkg::wide_type   tr_ff;
   logic [1:0]          t1i_ff, t1i_in;
   atd_pkg::data_type   t1r_ff [9];
   atd_pkg::side_b_type t1b_ff;

   always_comb begin
      t1i_in = 2'd0;
      if (r_ff[4] > r_ff[0]) begin
         t1i_in = 2'd1;
      end
      if (r_ff[8] > ((t1i_in == 2'd1) ? r_ff[4] : r_ff[0])) begin
         t1i_in = 2'd2;
      end
   end

   always_ff @(posedge clock) begin
      tr_ff  <= WW'(r_ff[0]) + WW'(r_ff[4]) + WW'(r_ff[8]);
      t1i_ff <= t1i_in;
      t1r_ff <= r_ff;
      t1b_ff <= rb_ff;
   end

   // branch selection: root argument, numerators and the slot the root fills
   function automatic logic [3:0] el(logic [1:0] col, logic [1:0] cmp);
      return 4'(col) * 4'd3 + 4'(cmp);
   endfunction

   atd_pkg::wide_type   rw [9];
   atd_pkg::wide_type   arg_a;
   atd_pkg::side_c_type c_in, c_ff;
   logic [63:0]         arg_in, arg_ff;
   logic [1:0]          ii, jj, kk;
   logic                trace;

   always_comb begin
      for (int e = 0; e < 9; e++) begin
         rw[e] = WW'(t1r_ff[e]);
      end
      ii = t1i_ff;
      case (t1i_ff)
         2'd0: begin
            jj = 2'd1;
            kk = 2'd2;
         end
         2'd1: begin
            jj = 2'd2;
            kk = 2'd0;
         end
         default: begin
            ii = 2'd2;
            jj = 2'd0;
            kk = 2'd1;
         end
      endcase
      trace    = tr_ff > 0;
      c_in.b   = t1b_ff;
      c_in.num = '0;
      if (trace) begin
         arg_a       = tr_ff + WW'(atd_pkg::QONE);
         c_in.num[1] = rw[5] - rw[7];
         c_in.num[2] = rw[6] - rw[2];
         c_in.num[3] = rw[1] - rw[3];
         c_in.slot   = 4'b0001;
      end else begin
         arg_a = rw[el(ii, ii)] - rw[el(jj, jj)] - rw[el(kk, kk)] +
                 WW'(atd_pkg::QONE);
         c_in.num[2'(jj + 2'd1)] = rw[el(ii, jj)] + rw[el(jj, ii)];
         c_in.num[2'(kk + 2'd1)] = rw[el(ii, kk)] + rw[el(kk, ii)];
         c_in.num[0]             = rw[el(jj, kk)] - rw[el(kk, jj)];
         c_in.slot               = 4'b0001 << (ii + 2'd1);
      end
      c_in.b.degen = t1b_ff.degen | (~trace & (arg_a <= 0));
      arg_in = (arg_a > 0) ? (64'($unsigned(arg_a)) << atd_pkg::QSHIFT) : 64'd0;
   end

   always_ff @(posedge clock) begin
      c_ff   <= c_in;
      arg_ff <= arg_in;
   end

   // quaternion root
   atd_pkg::sqrt_type   sqb_src [SQ];
   atd_pkg::sqrt_type   sqb_ff  [SQ];
   atd_pkg::side_c_type sc_src  [SQ];
   atd_pkg::side_c_type sc_ff   [SQ];

   for (genvar gk = 0; gk < SQ; gk++) begin : g_sqb
      if (gk == 0) begin : g_src
         assign sqb_src[gk] = {arg_ff, 64'd0};
         assign sc_src[gk]  = c_ff;
      end else begin : g_src
         assign sqb_src[gk] = sqb_ff[gk-1];
         assign sc_src[gk]  = sc_ff[gk-1];
      end
      always_ff @(posedge clock) begin
         sqb_ff[gk] <= atd_pkg::sqrt_step(sqb_src[gk], gk);
         sc_ff[gk]  <= sc_src[gk];
      end
   end

   // quotients over twice the root
   atd_pkg::side_c_type sc_last;
   atd_pkg::side_d_type d_start;
   logic [DW-1:0]       root;

   assign sc_last      = sc_ff[SQ-1];
   assign root         = sqb_ff[SQ-1].res[DW-1:0];
   assign d_start.b    = sc_last.b;
   assign d_start.slot = sc_last.slot;
   assign d_start.root = root;

   atd_pkg::div_type    dvb_src [DV][4];
   atd_pkg::div_type    dvb_ff  [DV][4];
   atd_pkg::side_d_type sd_src  [DV];
   atd_pkg::side_d_type sd_ff   [DV];

   for (genvar gk = 0; gk < DV; gk++) begin : g_dvb
      if (gk == 0) begin : g_src
         for (genvar gs = 0; gs < 4; gs++) begin : g_slot
            assign dvb_src[gk][gs] = atd_pkg::div_init(sc_last.num[gs],
                                        WW'({root, 1'b0}));
         end
         assign sd_src[gk] = d_start;
      end else begin : g_src
         assign dvb_src[gk] = dvb_ff[gk-1];
         assign sd_src[gk]  = sd_ff[gk-1];
      end
      for (genvar gs = 0; gs < 4; gs++) begin : g_step
         always_ff @(posedge clock) begin
            dvb_ff[gk][gs] <= atd_pkg::div_step(dvb_src[gk][gs], gk);
         end
      end
      always_ff @(posedge clock) begin
         sd_ff[gk] <= sd_src[gk];
      end
   end

   // output register
   atd_pkg::side_d_type sd_last;
   logic [atd_pkg::QUAT_WIDTH-1:0] qv [4];
   atd_pkg::rsp_type rsp_in, rsp_ff;

   assign sd_last = sd_ff[DV-1];

   always_comb begin
      for (int s = 0; s < 4; s++) begin
         qv[s] = sd_last.slot[s] ? {1'b0, sd_last.root[DW-1:1]}
                                 : atd_pkg::div_final(dvb_ff[DV-1][s]);
         if (sd_last.b.degen) begin
            qv[s] = '0;
         end
      end
      rsp_in.pos_x      = sd_last.b.pos[0];
      rsp_in.pos_y      = sd_last.b.pos[1];
      rsp_in.pos_z      = sd_last.b.pos[2];
      rsp_in.scale_x    = sd_last.b.scale[0];
      rsp_in.scale_y    = sd_last.b.scale[1];
      rsp_in.scale_z    = sd_last.b.scale[2];
      rsp_in.quat_w     = qv[0];
      rsp_in.quat_x     = qv[1];
      rsp_in.quat_y     = qv[2];
      rsp_in.quat_z     = qv[3];
      rsp_in.degenerate = sd_last.b.degen;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[LT-1];
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> design/atd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atd_checker
// Port-level checks on the transform decompose pipeline.
// ----------------------------------------------------------------------------
module atd_checker (
   input wire              clock,
   input wire              reset,
   input wire              start,
   input wire              busy,
   input wire              rsp_valid,
   input atd_pkg::rsp_type rsp_data
);

   localparam int LT = atd_pkg::LATENCY;

   logic signed [31:0] qpos, qneg;
   assign qpos = 32'sh4000_0000;
   assign qneg = -32'sh4000_0000;

   // every accepted beat yields exactly one result after the fixed latency
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LT rsp_valid)
      else $error("accepted beat produced no result");

   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LT))
      else $error("result without an accepted beat");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |->
      (rsp_data.quat_w == 0 && rsp_data.quat_x == 0 &&
       rsp_data.quat_y == 0 && rsp_data.quat_z == 0))
      else $error("degenerate result with nonzero quaternion");

   a_quat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      (rsp_data.quat_w <= qpos && rsp_data.quat_w >= qneg &&
       rsp_data.quat_x <= qpos && rsp_data.quat_x >= qneg &&
       rsp_data.quat_y <= qpos && rsp_data.quat_y >= qneg &&
       rsp_data.quat_z <= qpos && rsp_data.quat_z >= qneg))
      else $error("quaternion component out of range");

endmodule

bind affine_transform_decompose atd_checker u_atd_checker (.*);
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives transforms into affine_transform_decompose with random gaps and
// checks every result beat against a bit-exact decomposition predictor.
// ----------------------------------------------------------------------------

class decompose_board;
   atd_pkg::rsp_type pending[$];
   int               errors = 0;

   static function logic [63:0] root64(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // trunc(num * 2^30 / den), magnitude clamped at 2^30
   static function longint qdiv(longint num, logic [63:0] den);
      logic [63:0] m;
      logic [63:0] q;
      m = (num < 0) ? -num : num;
      q = (m << 30) / den;
      if (q > 64'd1073741824) q = 64'd1073741824;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function void note_transform(atd_pkg::req_type t);
      longint           cm[3][3];
      longint           rn[3][3];
      longint           qv[3];
      longint           w, tr, arg, lim;
      logic [63:0]      sc[3];
      logic [63:0]      sum, rt;
      bit               degen;
      int               i, j, k;
      atd_pkg::rsp_type e;
      cm[0] = '{t.c0x, t.c0y, t.c0z};
      cm[1] = '{t.c1x, t.c1y, t.c1z};
      cm[2] = '{t.c2x, t.c2y, t.c2z};
      qv = '{0, 0, 0};
      w = 0;
      degen = 0;
      lim = 64'd1 << 30;
      for (int a = 0; a < 3; a++) begin
         sum = 0;
         for (int b = 0; b < 3; b++) sum += cm[a][b] * cm[a][b];
         sc[a] = root64(sum);
         if (sc[a] == 0) degen = 1;
      end
      if (!degen) begin
         for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++) rn[a][b] = qdiv(cm[a][b], sc[a]);
         tr = rn[0][0] + rn[1][1] + rn[2][2];
         if (tr > 0) begin
            rt = root64((tr + lim) << 30);
            w = rt >> 1;
            qv[0] = qdiv(rn[1][2] - rn[2][1], 2 * rt);
            qv[1] = qdiv(rn[2][0] - rn[0][2], 2 * rt);
            qv[2] = qdiv(rn[0][1] - rn[1][0], 2 * rt);
         end else begin
            i = 0;
            if (rn[1][1] > rn[0][0]) i = 1;
            if (rn[2][2] > rn[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            arg = rn[i][i] - rn[j][j] - rn[k][k] + lim;
            if (arg <= 0) begin
               degen = 1;
            end else begin
               rt = root64(arg << 30);
               qv[i] = rt >> 1;
               qv[j] = qdiv(rn[i][j] + rn[j][i], 2 * rt);
               qv[k] = qdiv(rn[i][k] + rn[k][i], 2 * rt);
               w = qdiv(rn[j][k] - rn[k][j], 2 * rt);
            end
         end
      end
      if (degen) begin
         qv = '{0, 0, 0};
         w = 0;
      end
      e.pos_x = t.tx;
      e.pos_y = t.ty;
      e.pos_z = t.tz;
      e.scale_x = (sc[0] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sc[0][31:0];
      e.scale_y = (sc[1] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sc[1][31:0];
      e.scale_z = (sc[2] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sc[2][31:0];
      e.quat_w = w[31:0];
      e.quat_x = qv[0][31:0];
      e.quat_y = qv[1][31:0];
      e.quat_z = qv[2][31:0];
      e.degenerate = degen;
      pending.push_back(e);
   endfunction

   function void check_result(atd_pkg::rsp_type got);
      atd_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result beat %h", $time, got);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (e.pos_x !== got.pos_x || e.pos_y !== got.pos_y || e.pos_z !== got.pos_z)
         $display("%0t: pos expected %h %h %h actual %h %h %h", $time,
                  e.pos_x, e.pos_y, e.pos_z, got.pos_x, got.pos_y, got.pos_z);
      if (e.scale_x !== got.scale_x || e.scale_y !== got.scale_y ||
          e.scale_z !== got.scale_z)
         $display("%0t: scale expected %h %h %h actual %h %h %h", $time,
                  e.scale_x, e.scale_y, e.scale_z,
                  got.scale_x, got.scale_y, got.scale_z);
      if (e.quat_w !== got.quat_w || e.quat_x !== got.quat_x ||
          e.quat_y !== got.quat_y || e.quat_z !== got.quat_z)
         $display("%0t: quat expected %h %h %h %h actual %h %h %h %h", $time,
                  e.quat_w, e.quat_x, e.quat_y, e.quat_z,
                  got.quat_w, got.quat_x, got.quat_y, got.quat_z);
      if (e.degenerate !== got.degenerate)
         $display("%0t: degenerate expected %b actual %b", $time,
                  e.degenerate, got.degenerate);
      if (e !== got) errors++;
   endfunction
endclass

module testbench;

   localparam int STALL_LIMIT = 4 * atd_pkg::LATENCY + 2000;
   localparam int RANDOM_ITEMS = 1150;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   atd_pkg::req_type req_data;
   logic             rsp_valid;
   atd_pkg::rsp_type rsp_data;
   decompose_board   board;
   int               idle_cycles;

   affine_transform_decompose DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_transform(req_data);
         if (rsp_valid) board.check_result(rsp_data);
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic int gap_length();
      if ($urandom_range(0, 99) < 40) return 0;
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // hold start across back-to-back beats; lower it only for a gap
   task automatic send_transform(atd_pkg::req_type t);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic atd_pkg::data_type rand_comp(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(0, 131072)) - 65536;
         2: return $signed($urandom_range(0, 2000)) - 1000;
         default: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      endcase
   endfunction

   function automatic atd_pkg::req_type build(atd_pkg::data_type m[9],
                                              atd_pkg::data_type tr[3]);
      atd_pkg::req_type t;
      t = '{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8],
            tr[0], tr[1], tr[2]};
      return t;
   endfunction

   task automatic send_matrix(atd_pkg::data_type m[9]);
      atd_pkg::data_type tr[3];
      tr = '{$urandom(), $urandom(), $urandom()};
      send_transform(build(m, tr));
   endtask

   task automatic send_random();
      atd_pkg::data_type m[9];
      atd_pkg::data_type k;
      int                mode, pick;
      pick = $urandom_range(0, 99);
      mode = $urandom_range(0, 2);
      for (int n = 0; n < 9; n++) m[n] = rand_comp(mode);
      if (pick < 35) begin
         // scaled signed permutation: exercises every extraction branch
         k = $urandom_range(1, 1 << 20);
         m = '{default: 0};
         case ($urandom_range(0, 5))
            0: m = '{k, 0, 0, 0, k, 0, 0, 0, k};
            1: m = '{0, k, 0, k, 0, 0, 0, 0, k};
            2: m = '{0, 0, k, 0, k, 0, k, 0, 0};
            3: m = '{k, 0, 0, 0, 0, k, 0, k, 0};
            4: m = '{0, k, 0, 0, 0, k, k, 0, 0};
            default: m = '{0, 0, k, k, 0, 0, 0, k, 0};
         endcase
         for (int n = 0; n < 9; n++) begin
            if ($urandom_range(0, 1)) m[n] = -m[n];
            if ($urandom_range(0, 3) == 0)
               m[n] = m[n] + atd_pkg::data_type'($urandom_range(0, 4000)) - 2000;
         end
      end else if (pick < 45) begin
         for (int n = 0; n < 9; n++) if ($urandom_range(0, 3) == 0) m[n] = rand_comp(3);
      end else if (pick < 50) begin
         m[3 * $urandom_range(0, 2)] = 0;
         m[3 * $urandom_range(0, 2) + 1] = 0;
      end
      send_matrix(m);
   endtask

   initial begin
      atd_pkg::data_type one;
      atd_pkg::data_type mn;
      atd_pkg::data_type mx;
      board = new();
      idle_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      one = 32'sh0001_0000;
      mn = 32'sh8000_0000;
      mx = 32'sh7FFF_FFFF;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity, trace branch
      send_transform(build('{one, 0, 0, 0, one, 0, 0, 0, one}, '{mn, mx, 0}));
      // all-zero column: zero scale
      send_transform(build('{0, 0, 0, 0, one, 0, 0, 0, one}, '{mx, mn, -1}));
      send_transform(build('{one, 0, 0, 0, one, 0, 0, 0, 0}, '{1, 2, 3}));
      // 180 degree turns: one per diagonal pick
      send_matrix('{one, 0, 0, 0, -one, 0, 0, 0, -one});
      send_matrix('{-one, 0, 0, 0, one, 0, 0, 0, -one});
      send_matrix('{-one, 0, 0, 0, -one, 0, 0, 0, one});
      // reflection: largest-diagonal branch with a positive root argument
      send_matrix('{-one, 0, 0, 0, -one, 0, 0, 0, -one});
      // maximal lengths and extreme components
      send_matrix('{mn, mn, mn, mx, mx, mx, mn, mx, mn});
      send_matrix('{mx, 0, 0, 0, mx, 0, 0, 0, mx});
      send_matrix('{mn, 0, 0, 0, mn, 0, 0, 0, mn});
      send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
      send_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
      // near-reflections drive small roots and quotient clamping
      send_matrix('{-one, 3, 0, 5, -one, 0, 0, 0, -one + 7});
      send_matrix('{one, 0, 0, 0, -one, 1000, 0, -1000, -one});
      send_matrix('{0, one, 0, 0, 0, one, one, 0, 0});
      send_matrix('{0, -one, 0, one, 0, 0, 0, 0, -one});

      for (int n = 0; n < RANDOM_ITEMS; n++) send_random();
      @(negedge clock);
      start <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (atd_pkg::LATENCY + 10) @(posedge clock);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

>>> files.f
design/atd_pkg.sv
design/affine_transform_decompose.sv
design/atd_checker.sv
bench/testbench.sv
